/* sv/assert_macros.svh */
// Assertion helper macros shared by the RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/fmsr_pkg.sv */
// Shared types and constants for the first-match substring replace block.
// Depends on nothing; imported by every fmsr module.
`default_nettype none

package fmsr_pkg;

    localparam int DEF_MAX_PATTERN   = 8;
    localparam int DEF_POSITION_BITS = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int LANES             = 8;   // replacement text holds up to 8 characters

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        out_char_valid;
        logic        out_last;
        logic        match_found;
        logic [15:0] match_position;
    } out_item_t;

    // One queued job: a run of up to LANES characters, plus end-of-string info.
    typedef struct packed {
        logic [8*LANES-1:0] chars;
        logic [3:0]         count;
        logic               last;
        logic               found;
        logic [15:0]        position;
    } job_t;

endpackage

`default_nettype wire

/* sv/fmsr_front.sv */
// Front end: takes source characters, keeps the match window and issues jobs.
// Depends on fmsr_pkg.
`default_nettype none

module fmsr_front #(
    parameter int MAX_PATTERN   = fmsr_pkg::DEF_MAX_PATTERN,
    parameter int POSITION_BITS = fmsr_pkg::DEF_POSITION_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fmsr_pkg::cfg_t   cfg,
    input  wire logic             src_valid,
    output logic                  src_stall,
    input  wire fmsr_pkg::in_item_t src_data,
    input  wire logic             queue_full,
    output logic                  job_push,
    output fmsr_pkg::job_t        job
);
    import fmsr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int PW    = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    logic [7:0]               window_chars_reg  [MAX_PATTERN];
    logic [7:0]               window_chars_next [MAX_PATTERN];
    logic [7:0]               win_app           [MAX_PATTERN];
    logic [CNT_W-1:0]         window_count_reg, window_count_next;
    logic                     replaced_flag_reg, replaced_flag_next;
    logic [POSITION_BITS-1:0] source_index_reg, source_index_next;
    logic [POSITION_BITS-1:0] found_index_reg, found_index_next;
    logic [CNT_W-1:0]         cnt_app;
    logic [CNT_W-1:0]         plen_eff;
    logic [3:0]               rlen_eff;
    logic                     hit;
    logic                     take;
    logic [PW-1:0]            found_wide;

    assign src_stall = queue_full;
    assign take      = src_valid && !queue_full;
    assign cnt_app   = window_count_reg + CNT_W'(1);

    always_comb
    begin
        if (cfg.pattern_length == 4'd0)
            plen_eff = CNT_W'(1);
        else if (cfg.pattern_length > 4'(MAX_PATTERN))
            plen_eff = CNT_W'(MAX_PATTERN);
        else
            plen_eff = CNT_W'(cfg.pattern_length);

        rlen_eff = (cfg.replacement_length > 4'd8) ? 4'd8 : cfg.replacement_length;

        for (int i = 0; i < MAX_PATTERN; i++)
            win_app[i] = (CNT_W'(i) == window_count_reg) ? src_data.in_char
                                                          : window_chars_reg[i];

        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
            if (CNT_W'(i) < plen_eff && win_app[i] != cfg.pattern_bytes[8*i +: 8])
                hit = 1'b0;
    end

    always_comb
    begin
        window_chars_next  = window_chars_reg;
        window_count_next  = window_count_reg;
        replaced_flag_next = replaced_flag_reg;
        source_index_next  = source_index_reg;
        found_index_next   = found_index_reg;
        job_push           = 1'b0;
        job.chars          = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
            job.chars[8*i +: 8] = win_app[i];
        job.count    = 4'd1;
        job.last     = src_data.in_last;
        job.found    = 1'b0;
        job.position = '0;

        if (take)
        begin
            if (replaced_flag_reg)
            begin
                job.chars = {{(8*LANES-8){1'b0}}, src_data.in_char};
                job_push  = 1'b1;
            end
            else if (cnt_app > plen_eff || (cnt_app == plen_eff && !hit))
            begin
                // oldest character leaves; on the last item the whole window drains
                job.count = src_data.in_last ? 4'(cnt_app) : 4'd1;
                job_push  = 1'b1;
                for (int i = 0; i < MAX_PATTERN - 1; i++)
                    window_chars_next[i] = win_app[i + 1];
                window_chars_next[MAX_PATTERN-1] = 8'h00;
                window_count_next = cnt_app - CNT_W'(1);
                if (source_index_reg != '1)
                    source_index_next = source_index_reg + POSITION_BITS'(1);
            end
            else if (cnt_app == plen_eff)
            begin
                job.chars          = cfg.replacement_bytes;
                job.count          = rlen_eff;
                job_push           = (rlen_eff != 4'd0) || src_data.in_last;
                found_index_next   = source_index_reg;
                replaced_flag_next = 1'b1;
                window_count_next  = '0;
            end
            else
            begin
                window_chars_next = win_app;
                window_count_next = cnt_app;
                job.count         = 4'(cnt_app);
                job_push          = src_data.in_last;
            end

            found_wide   = PW'(found_index_next);
            job.found    = src_data.in_last && replaced_flag_next;
            job.position = job.found ? found_wide[15:0] : 16'd0;

            if (src_data.in_last)
            begin
                for (int i = 0; i < MAX_PATTERN; i++)
                    window_chars_next[i] = 8'h00;
                window_count_next  = '0;
                replaced_flag_next = 1'b0;
                source_index_next  = '0;
                found_index_next   = '0;
            end
        end
        else
        begin
            found_wide = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
                window_chars_reg[i] <= 8'h00;
            window_count_reg  <= '0;
            replaced_flag_reg <= 1'b0;
            source_index_reg  <= '0;
            found_index_reg   <= '0;
        end
        else
        begin
            window_chars_reg  <= window_chars_next;
            window_count_reg  <= window_count_next;
            replaced_flag_reg <= replaced_flag_next;
            source_index_reg  <= source_index_next;
            found_index_reg   <= found_index_next;
        end
    end

endmodule

`default_nettype wire

/* sv/fmsr_queue.sv */
// Short job queue between the front and back ends.
// Depends on fmsr_pkg (job_t, QUEUE_DEPTH).
`default_nettype none

module fmsr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire fmsr_pkg::job_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                pop_valid,
    output fmsr_pkg::job_t      pop_data
);
    import fmsr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* sv/fmsr_back.sv */
// Back end: expands queued jobs into output transactions, one per cycle while dst_stall is low.
// Depends on fmsr_pkg.
`default_nettype none

module fmsr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    input  wire fmsr_pkg::job_t job,
    output logic                job_pop,
    output logic                dst_valid,
    input  wire logic           dst_stall,
    output fmsr_pkg::out_item_t dst_data
);
    import fmsr_pkg::*;

    localparam int LANE_W = $clog2(LANES);

    logic [LANE_W-1:0] lane_reg, lane_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic              load;
    logic              is_final;
    logic              end_of_string;

    assign is_final      = (job.count == 4'd0) || ((4'(lane_reg) + 4'd1) >= job.count);
    assign load          = job_valid && (!out_valid_reg || !dst_stall);
    assign job_pop       = load && is_final;
    assign end_of_string = job.last && is_final;

    always_comb
    begin
        out_next       = out_reg;
        lane_next      = lane_reg;
        out_valid_next = out_valid_reg && dst_stall;
        if (load)
        begin
            out_valid_next          = 1'b1;
            lane_next               = is_final ? '0 : lane_reg + LANE_W'(1);
            out_next.out_char_valid = (job.count != 4'd0);
            out_next.out_char       = (job.count != 4'd0) ? job.chars[8*lane_reg +: 8] : 8'h00;
            out_next.out_last       = end_of_string;
            out_next.match_found    = end_of_string && job.found;
            out_next.match_position = end_of_string ? job.position : 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

endmodule

`default_nettype wire

/* sv/first_match_substring_replace.sv */
// Top level of the first-match substring replace block: config registers,
// front end, job queue and back end. Depends on fmsr_pkg, assert_macros.svh.
//
// Usage:
//  - src channel (src_valid/src_stall/src_data) carries one source character per
//    transaction, with in_last on the final character of a string.
//  - dst channel (dst_valid/dst_stall/dst_data) carries output characters. The final
//    transaction of a string has out_last set, plus match_found/match_position.
//    If a string ends with nothing to send, a bare end marker (out_char_valid 0) goes.
//  - cfg port: write pattern/replacement registers while the block is idle.
// A released character is written to a queue entry at the accepting edge and then
// loaded into the output register; characters are held back until the pattern
// window is full.
// Throughput: one source transaction per cycle while each produces at most one
// output; a match or end of string expands into up to 8 outputs, one per cycle
// while dst_stall is low, set by the single back-end output register. The 4-entry
// job queue absorbs the burst, then src_stall rises while it is full.
// Reset: clears the stream state and queue; pattern length resets to 1, others 0.
// A stalled receiver holds the output register, fills the queue and then stalls src.
`default_nettype none
`include "assert_macros.svh"

module first_match_substring_replace #(
    parameter int MAX_PATTERN   = fmsr_pkg::DEF_MAX_PATTERN,
    parameter int POSITION_BITS = fmsr_pkg::DEF_POSITION_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                src_valid,
    output logic                     src_stall,
    input  wire fmsr_pkg::in_item_t  src_data,
    output logic                     dst_valid,
    input  wire logic                dst_stall,
    output fmsr_pkg::out_item_t      dst_data,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [63:0]         cfg_wdata
);
    import fmsr_pkg::*;

    cfg_t cfg_reg, cfg_next;
    job_t push_job, head_job;
    logic job_push, job_pop, queue_full, head_valid;

    // Config register file; a write is seen by the next source transaction.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_BYTES:      cfg_next.pattern_bytes      = cfg_wdata;
                CFG_PATTERN_LENGTH:     cfg_next.pattern_length     = cfg_wdata[3:0];
                CFG_REPLACEMENT_BYTES:  cfg_next.replacement_bytes  = cfg_wdata;
                CFG_REPLACEMENT_LENGTH: cfg_next.replacement_length = cfg_wdata[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes      <= '0;
            cfg_reg.pattern_length     <= 4'd1;
            cfg_reg.replacement_bytes  <= '0;
            cfg_reg.replacement_length <= 4'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: window, compare and classification of each character.
    fmsr_front #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (push_job)
    );

    // Decouples the front from output bursts.
    fmsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (job_pop),
        .pop_valid (head_valid),
        .pop_data  (head_job)
    );

    // Back: one output transaction per cycle from the head job while dst_stall is low.
    fmsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_pop   (job_pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    // A bare end marker only ever closes a string.
    `ASSERT_CLK(a_marker_is_last, dst_valid && !dst_data.out_char_valid |-> dst_data.out_last, "bare marker without out_last")
    // Match report appears only on the final transaction of a string.
    `ASSERT_CLK(a_found_on_last, dst_valid && dst_data.match_found |-> dst_data.out_last, "match_found off the last transaction")
    // No match means a zero position.
    `ASSERT_CLK(a_pos_zero, dst_valid && !dst_data.match_found |-> dst_data.match_position == 16'd0, "nonzero position without match")
    // The queue never takes a job while full.
    `ASSERT_CLK(a_no_push_full, queue_full |-> !(src_valid && !src_stall), "transaction accepted with full queue")

endmodule

`default_nettype wire
